// ===== hw/rtl/tfn_pkg.sv =====
package tfn_pkg;

  // widths fixed by the stream fields
  localparam int IN_W   = 16;
  localparam int OUT_W  = 16;
  localparam int N_CORD = 9;
  localparam int N_COMP = 3;

endpackage

// ===== hw/rtl/tfn_sqrt_step.sv =====
// One bit of the restoring square-root search s = floor(sqrt(R / L)), three lanes.
// a holds s^2*L and b holds s*L for the bits decided so far.
module tfn_sqrt_step #(
  parameter int AW  = 102,
  parameter int LW  = 70,
  parameter int SBW = 16,
  parameter int BIT = 0
) (
  input  logic [LW-1:0]  l,
  input  logic [AW-1:0]  r      [tfn_pkg::N_COMP],
  input  logic [AW-1:0]  a      [tfn_pkg::N_COMP],
  input  logic [AW-1:0]  b      [tfn_pkg::N_COMP],
  input  logic [SBW-1:0] s      [tfn_pkg::N_COMP],
  output logic [AW-1:0]  a_next [tfn_pkg::N_COMP],
  output logic [AW-1:0]  b_next [tfn_pkg::N_COMP],
  output logic [SBW-1:0] s_next [tfn_pkg::N_COMP]
);

  logic [AW-1:0] l_ext;
  logic [AW-1:0] trial_a [tfn_pkg::N_COMP];
  logic [AW-1:0] trial_b [tfn_pkg::N_COMP];

  assign l_ext = AW'(l);

  always_comb begin
    for (int i = 0; i < tfn_pkg::N_COMP; i++) begin
      // (s + 2^k)^2 L = s^2 L + 2^(k+1) s L + 2^(2k) L
      trial_a[i] = a[i] + (b[i] << (BIT + 1)) + (l_ext << (2 * BIT));
      trial_b[i] = b[i] + (l_ext << BIT);
      if (trial_a[i] <= r[i]) begin
        a_next[i] = trial_a[i];
        b_next[i] = trial_b[i];
        s_next[i] = s[i] | (SBW'(1) << BIT);
      end else begin
        a_next[i] = a[i];
        b_next[i] = b[i];
        s_next[i] = s[i];
      end
    end
  end

endmodule

// ===== hw/rtl/triangle_face_normal_core.sv =====
// From input transfer to m_axis_tvalid a triangle passes five arithmetic stages,
// NORMAL_FRAC_BITS + 2 square-root bit stages and one output register.
// Throughput: one triangle per cycle; a two-entry output buffer (register plus skid) lets
// one more triangle in while a result waits, after which the whole pipe holds.
// Reset (rst, synchronous, active high) clears valid bits, output buffer and threshold.
module triangle_face_normal_core #(
  parameter int COORD_WIDTH      = 16,
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic         clk,
  input  logic         rst,
  // config: degenerate_threshold
  input  logic         cfg_wr_en,
  input  logic [63:0]  cfg_wr_data,
  // input stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata, low bit up: first_x, first_y, first_z, second_x, second_y, second_z,
  //                    third_x, third_y, third_z (16 bits each)
  input  logic [143:0] s_axis_tdata,
  // output stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata, low bit up: normal_x, normal_y, normal_z (16 bits each)
  output logic [47:0]  m_axis_tdata,
  // tuser: degenerate
  output logic [0:0]   m_axis_tuser
);

  localparam int CW   = COORD_WIDTH;
  localparam int F    = NORMAL_FRAC_BITS;
  localparam int DW   = CW + 1;           // edge vector component
  localparam int PW   = 2 * DW;           // partial product
  localparam int MW   = 2 * CW + 1;       // |cross component|
  localparam int SW   = 2 * MW;           // component squared
  localparam int LW   = SW + 2;           // squared length
  localparam int AW   = LW + 2 * F + 4;   // square-root accumulator
  localparam int SBW  = F + 2;            // root width
  localparam int NIT  = F + 2;            // root bit stages
  localparam int CMPW = (LW > 64) ? LW : 64;
  localparam int OW   = tfn_pkg::OUT_W;
  localparam int NC   = tfn_pkg::N_COMP;

  // ---------------------------------------------------------------- config
  logic [63:0] thr;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= '0;
    end else if (cfg_wr_en) begin
      thr <= cfg_wr_data;
    end
  end

  // ---------------------------------------------------------------- flow
  // The pipe advances whenever the skid slot is empty.
  logic en;
  logic skid_v;
  assign en            = !skid_v;
  assign s_axis_tready = en;

  // ---------------------------------------------------------------- stage 1: edges
  logic signed [CW-1:0] cord [tfn_pkg::N_CORD];
  logic signed [DW-1:0] ed_u [NC];
  logic signed [DW-1:0] ed_v [NC];
  logic                 v1;

  always_comb begin
    for (int i = 0; i < tfn_pkg::N_CORD; i++) begin
      // low CW bits of the zero-extended field, sign taken at bit CW-1
      cord[i] = signed'(CW'({16'b0, s_axis_tdata[tfn_pkg::IN_W*i +: tfn_pkg::IN_W]}));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NC; i++) begin
        ed_u[i] <= DW'(cord[3 + i]) - DW'(cord[i]);
        ed_v[i] <= DW'(cord[6 + i]) - DW'(cord[i]);
      end
    end
  end

  // ---------------------------------------------------------------- stage 2: products
  logic signed [PW-1:0] pa [NC];
  logic signed [PW-1:0] pb [NC];
  logic                 v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa[0] <= PW'(ed_u[1]) * PW'(ed_v[2]);
      pb[0] <= PW'(ed_u[2]) * PW'(ed_v[1]);
      pa[1] <= PW'(ed_u[2]) * PW'(ed_v[0]);
      pb[1] <= PW'(ed_u[0]) * PW'(ed_v[2]);
      pa[2] <= PW'(ed_u[0]) * PW'(ed_v[1]);
      pb[2] <= PW'(ed_u[1]) * PW'(ed_v[0]);
    end
  end

  // ---------------------------------------------------------------- stage 3: cross, magnitude
  logic signed [PW:0]   crs  [NC];
  logic [PW:0]          crs_abs [NC];
  logic [MW-1:0]        mag  [NC];
  logic                 neg3 [NC];
  logic                 v3;

  always_comb begin
    for (int i = 0; i < NC; i++) begin
      crs[i]     = (PW + 1)'(pa[i]) - (PW + 1)'(pb[i]);
      crs_abs[i] = crs[i][PW] ? (PW + 1)'(-crs[i]) : (PW + 1)'(crs[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NC; i++) begin
        mag[i]  <= crs_abs[i][MW-1:0];
        neg3[i] <= crs[i][PW];
      end
    end
  end

  // ---------------------------------------------------------------- stage 4: squares
  logic [SW-1:0] sq   [NC];
  logic          neg4 [NC];
  logic          v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NC; i++) begin
        sq[i]   <= SW'(mag[i]) * SW'(mag[i]);
        neg4[i] <= neg3[i];
      end
    end
  end

  // ---------------------------------------------------------------- stage 5: length, targets
  // it_*[0] is stage 5; it_*[k] is after root bit stage k.
  logic [LW-1:0]  it_l   [NIT+1];
  logic [AW-1:0]  it_r   [NIT+1][NC];
  logic [AW-1:0]  it_a   [NIT+1][NC];
  logic [AW-1:0]  it_b   [NIT+1][NC];
  logic [SBW-1:0] it_s   [NIT+1][NC];
  logic           it_neg [NIT+1][NC];
  logic           it_deg [NIT+1];
  logic           it_v   [NIT+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      it_v[0] <= 1'b0;
    end else if (en) begin
      it_v[0] <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it_l[0] <= LW'(sq[0]) + LW'(sq[1]) + LW'(sq[2]);
      for (int i = 0; i < NC; i++) begin
        // target 4 c^2 2^(2F)
        it_r[0][i]   <= AW'(sq[i]) << (2 * F + 2);
        it_neg[0][i] <= neg4[i];
      end
    end
  end

  always_comb begin
    it_deg[0] = CMPW'(it_l[0]) <= CMPW'(thr);
    for (int i = 0; i < NC; i++) begin
      it_a[0][i] = '0;
      it_b[0][i] = '0;
      it_s[0][i] = '0;
    end
  end

  // ---------------------------------------------------------------- root bit stages
  for (genvar g = 0; g < NIT; g++) begin : g_root
    logic [AW-1:0]  a_n [NC];
    logic [AW-1:0]  b_n [NC];
    logic [SBW-1:0] s_n [NC];

    tfn_sqrt_step #(
      .AW  (AW),
      .LW  (LW),
      .SBW (SBW),
      .BIT (NIT - 1 - g)
    ) u_step (
      .l      (it_l[g]),
      .r      (it_r[g]),
      .a      (it_a[g]),
      .b      (it_b[g]),
      .s      (it_s[g]),
      .a_next (a_n),
      .b_next (b_n),
      .s_next (s_n)
    );

    always_ff @(posedge clk) begin
      if (rst) begin
        it_v[g+1] <= 1'b0;
      end else if (en) begin
        it_v[g+1] <= it_v[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        it_l[g+1]   <= it_l[g];
        it_deg[g+1] <= it_deg[g];
        for (int i = 0; i < NC; i++) begin
          it_r[g+1][i]   <= it_r[g][i];
          it_a[g+1][i]   <= a_n[i];
          it_b[g+1][i]   <= b_n[i];
          it_s[g+1][i]   <= s_n[i];
          it_neg[g+1][i] <= it_neg[g][i];
        end
      end
    end
  end

  // ---------------------------------------------------------------- result
  // n = floor((s + 1) / 2) is the largest n with (2n-1)^2 L <= 4 c^2 2^(2F).
  logic [SBW-1:0]    s_inc [NC];
  logic signed [F+1:0] nrm [NC];
  logic [31:0]       nrm_ext [NC];
  logic [31:0]       one_ext;
  logic [3*OW:0]     res;

  always_comb begin
    one_ext = 32'(1) << F;
    for (int i = 0; i < NC; i++) begin
      s_inc[i]   = it_s[NIT][i] + SBW'(1);
      nrm[i]     = signed'((F + 2)'(s_inc[i][SBW-1:1]));
      if (it_neg[NIT][i]) begin
        nrm[i] = -nrm[i];
      end
      nrm_ext[i] = 32'(nrm[i]);
    end
    if (it_deg[NIT]) begin
      res = {1'b1, one_ext[OW-1:0], {OW{1'b0}}, {OW{1'b0}}};
    end else begin
      res = {1'b0, nrm_ext[2][OW-1:0], nrm_ext[1][OW-1:0], nrm_ext[0][OW-1:0]};
    end
  end

  // ---------------------------------------------------------------- output register + skid
  logic [3*OW:0] out_q;
  logic [3*OW:0] skid_q;
  logic          out_v;
  logic          push;

  assign push = en && it_v[NIT];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (out_v && !m_axis_tready) begin
      if (push) begin
        skid_v <= 1'b1;
      end
    end else if (skid_v) begin
      out_v  <= 1'b1;
      skid_v <= 1'b0;
    end else begin
      out_v <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (out_v && !m_axis_tready) begin
      if (push) begin
        skid_q <= res;
      end
    end else if (skid_v) begin
      out_q <= skid_q;
    end else if (push) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_v;
  assign m_axis_tdata  = out_q[3*OW-1:0];
  assign m_axis_tuser  = out_q[3*OW +: 1];

  // ---------------------------------------------------------------- checks
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> out_v)
    else $error("skid entry without output entry");

  a_deg_shape: assert property (@(posedge clk) disable iff (rst)
    (out_v && out_q[3*OW]) |-> (out_q[2*OW-1:0] == '0))
    else $error("degenerate result with nonzero x/y");

  a_normal_nonzero: assert property (@(posedge clk) disable iff (rst)
    (it_v[NIT] && !it_deg[NIT]) |-> (s_inc[0] > SBW'(1) || s_inc[1] > SBW'(1) ||
                                     s_inc[2] > SBW'(1)))
    else $error("nondegenerate triangle gave zero normal");

endmodule

// ===== dv/tfn_checker.sv =====
module tfn_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic [63:0]  cfg_wr_data,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [143:0] s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [47:0]  m_axis_tdata,
  input  logic [0:0]   m_axis_tuser,
  output int           errors,
  output int           pending,
  output int           n_results,
  output int           n_degen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 14;

  typedef struct packed {
    logic [tfn_pkg::OUT_W-1:0] nx;
    logic [tfn_pkg::OUT_W-1:0] ny;
    logic [tfn_pkg::OUT_W-1:0] nz;
    logic                      degen;
  } normal_t;

  normal_t     normal_q[$];
  logic [63:0] thr;

  // round(c * 2^FRAC / sqrt(len_sq)), ties away: largest n with (2n-1)^2*L <= 4c^2*2^2F
  function automatic logic [tfn_pkg::OUT_W-1:0] unit_comp(longint c, logic [127:0] len_sq);
    logic [127:0] mag, rhs, lhs, odd;
    longint q, cand;
    q   = 0;
    mag = (c < 0) ? 128'(-c) : 128'(c);
    rhs = (mag * mag) << (2 * FRAC + 2);
    for (int b = FRAC; b >= 0; b--) begin
      cand = q | (longint'(1) << b);
      if (cand <= (longint'(1) << FRAC)) begin
        odd = 128'(2 * cand - 1);
        lhs = odd * odd * len_sq;
        if (lhs <= rhs) q = cand;
      end
    end
    return (c < 0) ? tfn_pkg::OUT_W'(-q) : tfn_pkg::OUT_W'(q);
  endfunction

  function automatic normal_t face_normal(logic [143:0] d, logic [63:0] limit);
    longint p[tfn_pkg::N_CORD];
    longint ux, uy, uz, vx, vy, vz;
    longint c[tfn_pkg::N_COMP];
    logic [127:0] len_sq, m;
    normal_t r;
    for (int i = 0; i < tfn_pkg::N_CORD; i++)
      p[i] = longint'($signed(d[tfn_pkg::IN_W*i +: tfn_pkg::IN_W]));
    ux = p[3] - p[0]; uy = p[4] - p[1]; uz = p[5] - p[2];
    vx = p[6] - p[0]; vy = p[7] - p[1]; vz = p[8] - p[2];
    c[0] = uy * vz - uz * vy;
    c[1] = uz * vx - ux * vz;
    c[2] = ux * vy - uy * vx;
    len_sq = '0;
    for (int i = 0; i < tfn_pkg::N_COMP; i++) begin
      m = (c[i] < 0) ? 128'(-c[i]) : 128'(c[i]);
      len_sq += m * m;
    end
    if (len_sq <= 128'(limit)) begin
      r.nx = '0; r.ny = '0; r.nz = tfn_pkg::OUT_W'(1 << FRAC); r.degen = 1'b1;
    end else begin
      r.nx = unit_comp(c[0], len_sq);
      r.ny = unit_comp(c[1], len_sq);
      r.nz = unit_comp(c[2], len_sq);
      r.degen = 1'b0;
    end
    return r;
  endfunction

  task automatic report(string what, logic [tfn_pkg::OUT_W-1:0] got,
                        logic [tfn_pkg::OUT_W-1:0] want);
    $display("mismatch at %0t: %s got %0d want %0d", $realtime, what,
             $signed(got), $signed(want));
    errors++;
  endtask

  initial begin
    errors = 0; n_results = 0; n_degen = 0; pending = 0;
  end

  always @(posedge clk) begin
    normal_t w;
    if (rst) begin
      thr <= '0;
    end else begin
      // predict with the threshold in force before any write at this edge
      if (s_axis_tvalid && s_axis_tready)
        normal_q.insert(normal_q.size(), face_normal(s_axis_tdata, thr));
      if (cfg_wr_en) thr <= cfg_wr_data;
      if (m_axis_tvalid && m_axis_tready) begin
        n_results++;
        if (normal_q.size() == 0) begin
          $display("mismatch at %0t: result with nothing outstanding", $realtime);
          errors++;
        end else begin
          w = normal_q.pop_front();
          if (w.degen) n_degen++;
          if (m_axis_tdata[15:0]  !== w.nx) report("normal_x", m_axis_tdata[15:0], w.nx);
          if (m_axis_tdata[31:16] !== w.ny) report("normal_y", m_axis_tdata[31:16], w.ny);
          if (m_axis_tdata[47:32] !== w.nz) report("normal_z", m_axis_tdata[47:32], w.nz);
          if (m_axis_tuser[0] !== w.degen)
            report("degenerate", tfn_pkg::OUT_W'(m_axis_tuser[0]), tfn_pkg::OUT_W'(w.degen));
        end
      end
    end
    pending <= normal_q.size();
  end
endmodule

// ===== dv/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN       = 40;     // comfortably above the core's pipeline latency
  localparam int N_RANDOM    = 165;    // per threshold setting

  logic         clk, rst;
  logic         cfg_wr_en;
  logic [63:0]  cfg_wr_data;
  logic         s_axis_tvalid, s_axis_tready;
  logic [143:0] s_axis_tdata;
  logic         m_axis_tvalid, m_axis_tready;
  logic [47:0]  m_axis_tdata;
  logic [0:0]   m_axis_tuser;

  int errors, pending, n_results, n_degen;
  int cycles, sent, n_settings;
  bit tx_idle, rx_idle, held;
  int stall_left;

  triangle_face_normal_core DUT (
    .clk, .rst, .cfg_wr_en, .cfg_wr_data,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  tfn_checker checker_i (
    .clk, .rst, .cfg_wr_en, .cfg_wr_data,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .errors, .pending, .n_results, .n_degen
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("FAIL");
        $finish;
      end
    end
  end

  // receiver: random back-pressure, plus one long hold-off so the pipe and skid fill
  initial begin
    m_axis_tready = 1'b0;
    stall_left = 0;
    held = 0;
    forever begin
      @(posedge clk);
      if (!held && sent >= 300) begin
        held = 1;
        stall_left = 200;
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= !(rx_idle && $urandom_range(99) < 33);
      end
    end
  end

  function automatic logic [143:0] pack_tri(int p[tfn_pkg::N_CORD]);
    logic [143:0] d;
    for (int i = 0; i < tfn_pkg::N_CORD; i++)
      d[tfn_pkg::IN_W*i +: tfn_pkg::IN_W] = tfn_pkg::IN_W'(p[i]);
    return d;
  endfunction

  function automatic int rnd_coord(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  // random triangle: full range, tiny around a random spot, collinear, or mixed-scale
  function automatic logic [143:0] rnd_tri();
    int p[tfn_pkg::N_CORD];
    int k;
    case ($urandom_range(3))
      0: for (int i = 0; i < tfn_pkg::N_CORD; i++) p[i] = rnd_coord(-32768, 32767);
      1: begin
        for (int i = 0; i < 3; i++) p[i] = rnd_coord(-32000, 32000);
        for (int i = 3; i < tfn_pkg::N_CORD; i++) p[i] = p[i % 3] + rnd_coord(-3, 3);
      end
      2: begin
        // p2 on the line through p0 and p1: zero area
        k = rnd_coord(-3, 3);
        for (int i = 0; i < 3; i++) begin
          p[i]   = rnd_coord(-8000, 8000);
          p[i+3] = p[i] + rnd_coord(-200, 200);
          p[i+6] = p[i] + k * (p[i+3] - p[i]);
        end
      end
      default: begin
        for (int i = 0; i < 3; i++) p[i] = rnd_coord(-32768, 32767);
        for (int i = 3; i < tfn_pkg::N_CORD; i++)
          p[i] = rnd_coord(-32768, 32767) >>> $urandom_range(15);
      end
    endcase
    return pack_tri(p);
  endfunction

  task automatic send(logic [143:0] d);
    if (tx_idle && $urandom_range(99) < 33) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    do @(posedge clk); while (!s_axis_tready);
    sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    // let the checker's count catch up with the last transfer
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic set_threshold(logic [63:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    n_settings++;
  endtask

  task automatic directed();
    int p[tfn_pkg::N_CORD];
    p = '{default: -32768};                                    send(pack_tri(p));
    p = '{default: 32767};                                     send(pack_tri(p));
    p = '{default: 0};                                         send(pack_tri(p));
    // widest triangles, both windings
    p = '{-32768, -32768, -32768, 32767, -32768, 32767, -32768, 32767, 32767};
    send(pack_tri(p));
    p = '{-32768, -32768, -32768, -32768, 32767, 32767, 32767, -32768, 32767};
    send(pack_tri(p));
    p = '{32767, 32767, 32767, -32768, 32767, -32768, 32767, -32768, -32768};
    send(pack_tri(p));
    // axis-aligned faces: normals along +z, -z, +x, -x, +y, -y
    p = '{0, 0, 0, 1, 0, 0, 0, 1, 0};                          send(pack_tri(p));
    p = '{0, 0, 0, 0, 1, 0, 1, 0, 0};                          send(pack_tri(p));
    p = '{5, 5, 5, 5, 6, 5, 5, 5, 6};                          send(pack_tri(p));
    p = '{5, 5, 5, 5, 5, 6, 5, 6, 5};                          send(pack_tri(p));
    p = '{-7, 3, 0, -7, 3, 100, 20, 3, 0};                     send(pack_tri(p));
    p = '{-7, 3, 0, 20, 3, 0, -7, 3, 100};                     send(pack_tri(p));
    // equal components, equal magnitudes with mixed signs, a 3-4-5 normal in the xy plane
    p = '{0, 0, 0, 1, -1, 0, 0, 1, -1};                        send(pack_tri(p));
    p = '{0, 0, 0, 1, 1, 0, 1, 2, 1};                          send(pack_tri(p));
    p = '{0, 0, 0, 3, 4, 0, 0, 0, 1};                          send(pack_tri(p));
    // collinear, repeated corners, nearly collinear
    p = '{1, 2, 3, 2, 4, 6, 3, 6, 9};                          send(pack_tri(p));
    p = '{-32768, 0, 32767, -32768, 0, 32767, 1, 1, 1};         send(pack_tri(p));
    p = '{32767, -32768, 0, -32768, 32767, 0, 32767, -32768, 0}; send(pack_tri(p));
    p = '{-32768, 32767, -32768, 32767, -32768, 32767, 0, 0, 0}; send(pack_tri(p));
  endtask

  initial begin
    logic [63:0] setting[6];
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    tx_idle = 1;
    rx_idle = 1;
    sent = 0;
    n_settings = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    setting[0] = 64'd0;
    setting[1] = 64'd1;
    setting[2] = 64'd40;
    setting[3] = 64'hFFFF_FFFF_FFFF_FFFF;
    setting[4] = 64'($urandom);
    setting[5] = {$urandom, $urandom};

    foreach (setting[s]) begin
      drain();
      set_threshold(setting[s]);
      // one setting runs without any idling on either side
      tx_idle = (s != 2);
      rx_idle = (s != 2);
      directed();
      for (int n = 0; n < N_RANDOM; n++) send(rnd_tri());
    end
    drain();

    $display("%0d triangles sent across %0d threshold settings (zero to all-ones)",
             sent, n_settings);
    $display("%0d normals checked, %0d of them degenerate", n_results, n_degen);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
